/* rtl/double_ended_queue_top_defines.svh */
// Assertion macros for the double-ended queue.
// Included by double_ended_queue_top.sv; needs nothing else.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define DEQ_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("double-ended queue check failed");

// Check that holds in the cycle after its condition.
`define DEQ_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("double-ended queue check failed");

`endif

/* rtl/deq_pkg.sv */
// Shared types, constants and pointer helpers for the double-ended queue.
// Used by deq_mem, deq_core and double_ended_queue_top; depends on nothing.
package deq_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(DEPTH - 1);

  // Command codes; codes above peek behave as peek.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic [STATUS_W-1:0]          status;
    logic [COUNT_W-1:0]           count;
    logic                         is_empty;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
  } deq_out_t;

  // Request bundle from the control logic to the word store.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re_front;
    logic [ADDR_W-1:0]     raddr_front;
    logic                  re_back;
    logic [ADDR_W-1:0]     raddr_back;
  } deq_mem_req_t;

  // Circular pointer step forward, wrapping at the last slot.
  function automatic logic [ADDR_W-1:0] inc_ptr(input logic [ADDR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + ADDR_W'(1);
  endfunction

  // Circular pointer step backward, wrapping at slot zero.
  function automatic logic [ADDR_W-1:0] dec_ptr(input logic [ADDR_W-1:0] p);
    return (p == '0) ? LAST_SLOT : p - ADDR_W'(1);
  endfunction

endpackage

/* rtl/double_ended_queue_top.sv */
// Top level of the double-ended queue: input register, queue core, result register.
// Depends on deq_pkg, deq_core (with deq_mem) and the assertion macro header.
//
// Usage:
//   A command item (req.cmd, req.value) is taken at a rising edge where start
//   is high and busy is low. busy is never raised, so one item may be given in
//   every cycle.
//   Each item gives exactly one result on the result port, marked by done for
//   one cycle. The item passes through the input register and the update
//   logic into the result register, which loads at the edge after the one
//   that takes the item, so the result is on the port in the following cycle.
//   One item is taken per cycle.
//   The words at each end of the queue are kept in registers; a pop refills
//   them from the 1024-entry store through its registered read ports, so the
//   refill lands in time for the next item.
//   The result port cannot be held off; a result not taken in its cycle is
//   gone.
//   Reset (rst, synchronous) empties the queue and drops any item in flight.
//   Store contents are not cleared; only written slots are ever read.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  deq_in_t  req,
  output logic     done,
  output deq_out_t result
);

  logic     s1_valid;
  deq_in_t  s1_item;
  deq_out_t core_res;

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_item <= req;
    end
  end

  deq_core u_core (
    .clk      (clk),
    .rst      (rst),
    .op_valid (s1_valid),
    .op       (s1_item),
    .res      (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result <= core_res;
    end
  end

  // Consistency checks on delivered results.
  `DEQ_ASSERT_SAME(a_empty_flag, clk, rst, done, result.is_empty == (result.count == '0))
  `DEQ_ASSERT_SAME(a_full_count, clk, rst, done && result.status == ST_FULL, result.count == DEPTH_CNT)
  `DEQ_ASSERT_SAME(a_empty_ends, clk, rst, done && result.status == ST_EMPTY, result.is_empty && result.front_value == '1 && result.back_value == '1)
  `DEQ_ASSERT_NEXT(a_count_step, clk, rst, done, !done || result.count == $past(result.count) || result.count == $past(result.count) + COUNT_W'(1) || result.count == $past(result.count) - COUNT_W'(1))

endmodule

/* rtl/deq_mem.sv */
// Word store for the double-ended queue: one write port, two registered read ports.
// Depends on deq_pkg for sizes and the request bundle.
module deq_mem
  import deq_pkg::*;
(
  input  logic                  clk,
  input  deq_mem_req_t          req,
  output logic [DATA_WIDTH-1:0] rdata_front,
  output logic [DATA_WIDTH-1:0] rdata_back
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read ports; data holds until the next read on the same port.
  always_ff @(posedge clk) begin
    if (req.re_front) begin
      rdata_front <= mem[req.raddr_front];
    end
    if (req.re_back) begin
      rdata_back <= mem[req.raddr_back];
    end
  end

endmodule

/* rtl/deq_core.sv */
// Queue state and per-item update logic for the double-ended queue.
// Keeps the two words at each end in registers and refills them from deq_mem.
// Depends on deq_pkg and deq_mem.
module deq_core
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  input  deq_in_t  op,
  output deq_out_t res
);

  logic [ADDR_W-1:0]     head, head_next;
  logic [ADDR_W-1:0]     tail, tail_next;
  logic [COUNT_W-1:0]    cnt, cnt_next;
  logic [DATA_WIDTH-1:0] front_q, front_next;
  logic [DATA_WIDTH-1:0] back_q, back_next;
  logic [DATA_WIDTH-1:0] front2_q, front2_next;
  logic [DATA_WIDTH-1:0] back2_q, back2_next;
  logic                  f2_pend, f2_pend_next;
  logic                  b2_pend, b2_pend_next;

  logic [DATA_WIDTH-1:0] rdata_front, rdata_back;
  logic [DATA_WIDTH-1:0] front2_eff, back2_eff;
  logic [DATA_WIDTH-1:0] popped;
  logic [STATUS_W-1:0]   status;
  logic                  is_full, is_empty_now, has_three;
  deq_mem_req_t          mem_req;

  deq_mem u_mem (
    .clk         (clk),
    .req         (mem_req),
    .rdata_front (rdata_front),
    .rdata_back  (rdata_back)
  );

  // The second word at each end comes from the store when a refill is pending.
  assign front2_eff   = f2_pend ? rdata_front : front2_q;
  assign back2_eff    = b2_pend ? rdata_back : back2_q;
  assign is_full      = (cnt == DEPTH_CNT);
  assign is_empty_now = (cnt == '0);
  assign has_three    = (cnt > COUNT_W'(2));

  // Next state, store access and result fields for the item at hand.
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    cnt_next     = cnt;
    front_next   = front_q;
    back_next    = back_q;
    front2_next  = front2_eff;
    back2_next   = back2_eff;
    f2_pend_next = 1'b0;
    b2_pend_next = 1'b0;
    popped       = '0;
    status       = ST_OK;
    mem_req      = '0;

    if (op_valid) begin
      unique case (op.cmd)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = dec_ptr(head);
            mem_req.wdata = op.value;
            head_next     = dec_ptr(head);
            cnt_next      = cnt + COUNT_W'(1);
            front_next    = op.value;
            front2_next   = front_q;
            if (is_empty_now) begin
              back_next = op.value;
            end
            if (cnt == COUNT_W'(1)) begin
              back2_next = op.value;
            end
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tail;
            mem_req.wdata = op.value;
            tail_next     = inc_ptr(tail);
            cnt_next      = cnt + COUNT_W'(1);
            back_next     = op.value;
            back2_next    = back_q;
            if (is_empty_now) begin
              front_next = op.value;
            end
            if (cnt == COUNT_W'(1)) begin
              front2_next = op.value;
            end
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty_now) begin
            popped = '1;
            status = ST_EMPTY;
          end else begin
            popped     = front_q;
            head_next  = inc_ptr(head);
            cnt_next   = cnt - COUNT_W'(1);
            front_next = front2_eff;
            // Refill the second word from two slots past the old head.
            if (has_three) begin
              mem_req.re_front    = 1'b1;
              mem_req.raddr_front = inc_ptr(inc_ptr(head));
              f2_pend_next        = 1'b1;
            end
          end
        end
        CMD_POP_BACK: begin
          if (is_empty_now) begin
            popped = '1;
            status = ST_EMPTY;
          end else begin
            popped    = back_q;
            tail_next = dec_ptr(tail);
            cnt_next  = cnt - COUNT_W'(1);
            back_next = back2_eff;
            // Refill the second word from three slots before the old tail.
            if (has_three) begin
              mem_req.re_back    = 1'b1;
              mem_req.raddr_back = dec_ptr(dec_ptr(dec_ptr(tail)));
              b2_pend_next       = 1'b1;
            end
          end
        end
        default: begin
          if (is_empty_now) begin
            status = ST_EMPTY;
          end
        end
      endcase
    end
  end

  // Result fields describe the queue after the item.
  always_comb begin
    res.popped_value = popped;
    res.status       = status;
    res.count        = cnt_next;
    res.is_empty     = (cnt_next == '0);
    res.front_value  = (cnt_next == '0) ? '1 : front_next;
    res.back_value   = (cnt_next == '0) ? '1 : back_next;
  end

  // Pointers, count and refill flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      cnt     <= '0;
      f2_pend <= 1'b0;
      b2_pend <= 1'b0;
    end else if (op_valid) begin
      head    <= head_next;
      tail    <= tail_next;
      cnt     <= cnt_next;
      f2_pend <= f2_pend_next;
      b2_pend <= b2_pend_next;
    end
  end

  // Cached end words.
  always_ff @(posedge clk) begin
    if (op_valid) begin
      front_q  <= front_next;
      back_q   <= back_next;
      front2_q <= front2_next;
      back2_q  <= back2_next;
    end
  end

endmodule
